// ----- hw/rtl/track_marker_detector_unit_macros.svh -----
// Assertion macros shared by the track marker detector RTL.
`ifndef TRACK_MARKER_DETECTOR_UNIT_MACROS_SVH
`define TRACK_MARKER_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TMD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TMD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/tmd_pkg.sv -----
// Types and constants of the track marker detector.
`default_nettype none
package tmd_pkg;

  localparam int unsigned DIST_W   = 32;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARKER_LENGTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CROSS_LENGTH   = 2'd3;

  // Reset values of the configuration registers
  localparam logic signed [SAMPLE_W-1:0] HIGH_THRESHOLD_RST = 16'sd800;
  localparam logic signed [SAMPLE_W-1:0] LOW_THRESHOLD_RST  = 16'sd500;
  localparam logic [DIST_W-1:0]          MARKER_LENGTH_RST  = 32'd10000;
  localparam logic [DIST_W-1:0]          CROSS_LENGTH_RST   = 32'd40400;

  // Reported marker kind
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_LEFT  = 2'd1,
    KIND_RIGHT = 2'd2,
    KIND_CROSS = 2'd3
  } tmd_kind_t;

  // Tracking state of one sensor side
  typedef struct packed {
    logic              seen;
    logic              confirmed;
    logic [DIST_W-1:0] start;
  } tmd_side_t;

  // One marker report
  typedef struct packed {
    tmd_kind_t         kind;
    logic [DIST_W-1:0] at;
  } tmd_report_t;

  localparam tmd_side_t SIDE_CLEAR = '{seen: 1'b0, confirmed: 1'b0, start: '0};

endpackage
`default_nettype wire

// ----- hw/rtl/track_marker_detector_unit.sv -----
// Track marker detector: hysteresis comparators and left/right/cross marker tracking.
//
// One result per input transfer, one transfer per cycle when the output side
// keeps up: the input is decided by one pass of compare, subtract and add logic
// and lands in the output register the cycle it is taken; in_ready stays high
// while that register is empty or being drained. Configuration is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while idle, as the block
// does not check. The thresholds take the low 16 bits of cfg_data as a signed value.
`default_nettype none
module track_marker_detector_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration
  input  wire logic                                cfg_we,
  input  wire logic [tmd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [tmd_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input channel
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire logic signed [tmd_pkg::SAMPLE_W-1:0] left_sample,
  input  wire logic signed [tmd_pkg::SAMPLE_W-1:0] right_sample,
  input  wire logic [tmd_pkg::DIST_W-1:0]          travelled,
  // output channel
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      logic                                left_level,
  output      logic                                right_level,
  output      logic [1:0]                          marker_kind,
  output      logic [tmd_pkg::DIST_W-1:0]          marker_at
);
  import tmd_pkg::*;

  `include "track_marker_detector_unit_macros.svh"

  // Pick the report from the confirmed flags and starts
  function automatic tmd_report_t make_report(input tmd_side_t l, input tmd_side_t r);
    tmd_report_t       rep;
    logic [DIST_W:0]   sum;
    sum = {1'b0, l.start} + {1'b0, r.start};
    if (l.confirmed && r.confirmed) begin
      rep.kind = KIND_CROSS;
      rep.at   = sum[DIST_W:1];
    end else if (l.confirmed) begin
      rep.kind = KIND_LEFT;
      rep.at   = l.start;
    end else if (r.confirmed) begin
      rep.kind = KIND_RIGHT;
      rep.at   = r.start;
    end else begin
      rep.kind = KIND_NONE;
      rep.at   = '0;
    end
    return rep;
  endfunction

  // Configuration registers
  logic signed [SAMPLE_W-1:0] high_threshold;
  logic signed [SAMPLE_W-1:0] low_threshold;
  logic [DIST_W-1:0]          marker_length;
  logic [DIST_W-1:0]          cross_length;

  // Tracking state
  logic      left_hyst;
  logic      right_hyst;
  tmd_side_t left_side;
  tmd_side_t right_side;

  logic      left_hyst_next;
  logic      right_hyst_next;
  tmd_side_t left_side_next;
  tmd_side_t right_side_next;
  tmd_report_t report_next;

  logic              accept;
  logic              left_reg;
  logic              right_reg;
  logic [DIST_W-1:0] left_dist;
  logic [DIST_W-1:0] right_dist;
  tmd_side_t         left_mid;
  tmd_side_t         right_mid;
  tmd_report_t       left_rep;
  tmd_report_t       right_rep;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Configuration write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      high_threshold <= HIGH_THRESHOLD_RST;
      low_threshold  <= LOW_THRESHOLD_RST;
      marker_length  <= MARKER_LENGTH_RST;
      cross_length   <= CROSS_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HIGH_THRESHOLD: high_threshold <= cfg_data[SAMPLE_W-1:0];
        REG_LOW_THRESHOLD:  low_threshold  <= cfg_data[SAMPLE_W-1:0];
        REG_MARKER_LENGTH:  marker_length  <= cfg_data[DIST_W-1:0];
        REG_CROSS_LENGTH:   cross_length   <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // One step: comparators, left side, then right side
  always_comb begin
    left_hyst_next  = left_hyst  ? !(left_sample  < low_threshold)
                                 : (left_sample  > high_threshold);
    right_hyst_next = right_hyst ? !(right_sample < low_threshold)
                                 : (right_sample > high_threshold);

    // left side
    left_dist = travelled - left_side.start;
    left_mid  = left_side;
    right_mid = right_side;
    left_reg  = 1'b0;
    left_rep  = make_report(left_side, right_side);
    if (left_hyst_next) begin
      if (!left_side.seen) begin
        left_mid.seen  = 1'b1;
        left_mid.start = travelled;
      end else if (!left_side.confirmed && left_dist >= marker_length) begin
        left_mid.confirmed = 1'b1;
      end
    end else if (left_side.seen && left_dist >= cross_length) begin
      left_reg  = 1'b1;
      left_mid  = SIDE_CLEAR;
      right_mid = SIDE_CLEAR;
    end

    // right side, seeing what the left side left behind
    right_dist      = travelled - right_mid.start;
    left_side_next  = left_mid;
    right_side_next = right_mid;
    right_reg       = 1'b0;
    right_rep       = make_report(left_mid, right_mid);
    if (right_hyst_next) begin
      if (!right_mid.seen) begin
        right_side_next.seen  = 1'b1;
        right_side_next.start = travelled;
      end else if (!right_mid.confirmed && right_dist >= marker_length) begin
        right_side_next.confirmed = 1'b1;
      end
    end else if (right_mid.seen && right_dist >= cross_length) begin
      right_reg       = 1'b1;
      left_side_next  = SIDE_CLEAR;
      right_side_next = SIDE_CLEAR;
    end

    // a report without a marker has kind none and position zero
    if (right_reg) begin
      report_next = right_rep;
    end else if (left_reg) begin
      report_next = left_rep;
    end else begin
      report_next = '{kind: KIND_NONE, at: '0};
    end
  end

  // State update on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      left_hyst  <= 1'b0;
      right_hyst <= 1'b0;
      left_side  <= SIDE_CLEAR;
      right_side <= SIDE_CLEAR;
    end else if (accept) begin
      left_hyst  <= left_hyst_next;
      right_hyst <= right_hyst_next;
      left_side  <= left_side_next;
      right_side <= right_side_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      left_level  <= left_hyst_next;
      right_level <= right_hyst_next;
      marker_kind <= report_next.kind;
      marker_at   <= report_next.at;
    end
  end

  // Checks
  `TMD_ASSERT_IMP(a_conf_needs_seen_l, clk, rst, left_side.confirmed, left_side.seen,
    "left side confirmed without a start")
  `TMD_ASSERT_IMP(a_conf_needs_seen_r, clk, rst, right_side.confirmed, right_side.seen,
    "right side confirmed without a start")
  `TMD_ASSERT_NXT(a_right_reg_clears, clk, rst, accept && right_reg,
    !left_side.seen && !right_side.seen, "right registration did not clear both sides")
  `TMD_ASSERT_IMP(a_none_at_zero, clk, rst,
    out_valid && (marker_kind == KIND_NONE), marker_at == '0,
    "marker position set with no marker")

endmodule
`default_nettype wire
